// ===== src/apt_pkg.sv =====
// Shared types and constants of the affine point transform.
// Used by every module under src; depends on nothing.
package apt_pkg;

  // Default width of coordinate words (Q16.16 at 32 bits)
  localparam int unsigned COORD_W_DEF = 32;

  // Rotation coefficients: signed Q2.14, three to a 48-bit row register
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DIM       = 3;
  localparam int unsigned ROW_W     = DIM * COEF_W;

  // Translation registers are at most 32 bits wide (narrower if the coordinate is)
  localparam int unsigned TRANS_W = 32;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  // Identity coefficient, 1.0 in Q2.14
  localparam logic signed [COEF_W-1:0] COEF_ONE = 16'sd16384;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Request command, carried in tuser
  typedef enum logic [1:0] {
    CMD_POINT     = 2'd0,
    CMD_INV_POINT = 2'd1,
    CMD_DIR       = 2'd2,
    CMD_INV_DIR   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5
  } cfg_idx_t;

  // Per-request flags that travel down the pipeline
  typedef struct packed {
    logic inverse;  // use the transposed rotation
    logic add_t;    // add translation after rounding
  } op_flags_t;

endpackage

// ===== src/apt_prep.sv =====
// Stage 1: decode the command and form the operand vector (v - t for the
// inverse point). Depends on apt_pkg.
module apt_prep #(
  parameter int unsigned CW = apt_pkg::COORD_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  apt_pkg::cmd_t            cmd_i,
  input  logic signed [CW-1:0]     vin_i   [apt_pkg::DIM],
  input  logic signed [CW-1:0]     trans_i [apt_pkg::DIM],
  output logic                     valid_o,
  input  logic                     ready_i,
  output apt_pkg::op_flags_t       flags_o,
  output logic signed [CW:0]       opnd_o  [apt_pkg::DIM]
);
  import apt_pkg::*;

  localparam int unsigned DW = CW + 1;

  logic                valid_r;
  op_flags_t           flags_r;
  op_flags_t           flags_nxt;
  logic signed [DW-1:0] opnd_r   [DIM];
  logic signed [DW-1:0] opnd_nxt [DIM];

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign opnd_o  = opnd_r;

  // Decode the command and subtract translation for the inverse point
  always_comb begin
    flags_nxt.inverse = (cmd_i == CMD_INV_POINT) || (cmd_i == CMD_INV_DIR);
    flags_nxt.add_t   = (cmd_i == CMD_POINT);
    for (int i = 0; i < DIM; i++) begin
      if (cmd_i == CMD_INV_POINT) begin
        opnd_nxt[i] = DW'(vin_i[i]) - DW'(trans_i[i]);
      end else begin
        opnd_nxt[i] = DW'(vin_i[i]);
      end
    end
  end

  // Hold the stage valid until the next stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      flags_r <= flags_nxt;
      opnd_r  <= opnd_nxt;
    end
  end

endmodule

// ===== src/apt_mul.sv =====
// Stage 2: nine signed products of operand and rotation coefficient,
// transposed for the inverse commands. Depends on apt_pkg.
module apt_mul #(
  parameter int unsigned CW = apt_pkg::COORD_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  apt_pkg::op_flags_t         flags_i,
  input  logic signed [CW:0]         opnd_i [apt_pkg::DIM],
  input  apt_pkg::coef_t             rot_i  [apt_pkg::DIM][apt_pkg::DIM],
  output logic                       valid_o,
  input  logic                       ready_i,
  output apt_pkg::op_flags_t         flags_o,
  output logic signed [CW+16:0]      prod_o [apt_pkg::DIM][apt_pkg::DIM]
);
  import apt_pkg::*;

  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = DW + COEF_W;

  logic                 valid_r;
  op_flags_t            flags_r;
  coef_t                coef     [DIM][DIM];
  logic signed [PW-1:0] prod_r   [DIM][DIM];
  logic signed [PW-1:0] prod_nxt [DIM][DIM];

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign prod_o  = prod_r;

  // Pick row or column of R, then multiply term by term
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      for (int k = 0; k < DIM; k++) begin
        coef[i][k]     = flags_i.inverse ? rot_i[k][i] : rot_i[i][k];
        prod_nxt[i][k] = PW'(opnd_i[k]) * PW'(coef[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      flags_r <= flags_i;
      prod_r  <= prod_nxt;
    end
  end

endmodule

// ===== src/apt_sum.sv =====
// Stage 3: add the three products of each row together with the
// half-LSB rounding constant. Depends on apt_pkg.
module apt_sum #(
  parameter int unsigned CW = apt_pkg::COORD_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  apt_pkg::op_flags_t         flags_i,
  input  logic signed [CW+16:0]      prod_i [apt_pkg::DIM][apt_pkg::DIM],
  output logic                       valid_o,
  input  logic                       ready_i,
  output apt_pkg::op_flags_t         flags_o,
  output logic signed [CW+18:0]      sum_o  [apt_pkg::DIM]
);
  import apt_pkg::*;

  localparam int unsigned PW = CW + 1 + COEF_W;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (FRAC_BITS - 1);

  logic                 valid_r;
  op_flags_t            flags_r;
  logic signed [SW-1:0] sum_r   [DIM];
  logic signed [SW-1:0] sum_nxt [DIM];

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign sum_o   = sum_r;

  // Exact dot product plus rounding offset, ties go up
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      sum_nxt[i] = SW'(prod_i[i][0]) + SW'(prod_i[i][1]) + SW'(prod_i[i][2]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      flags_r <= flags_i;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== src/apt_sat.sv =====
// Stage 4: drop the fraction bits, add translation for the point command,
// saturate and hold the result in the output register. Depends on apt_pkg.
module apt_sat #(
  parameter int unsigned CW = apt_pkg::COORD_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  apt_pkg::op_flags_t         flags_i,
  input  logic signed [CW+18:0]      sum_i   [apt_pkg::DIM],
  input  logic signed [CW-1:0]       trans_i [apt_pkg::DIM],
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [CW-1:0]       vout_o  [apt_pkg::DIM],
  output logic                       sat_o
);
  import apt_pkg::*;

  localparam int unsigned SW = CW + 1 + COEF_W + 2;
  localparam int unsigned QW = SW - FRAC_BITS;
  localparam int unsigned RW = QW + 1;
  localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

  logic                 valid_r;
  logic signed [CW-1:0] vout_r   [DIM];
  logic signed [CW-1:0] vout_nxt [DIM];
  logic                 sat_r;
  logic                 sat_nxt;
  logic signed [QW-1:0] quot     [DIM];
  logic signed [RW-1:0] res      [DIM];
  logic [RW-CW:0]       top_bits [DIM];
  logic                 fits     [DIM];

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign vout_o  = vout_r;
  assign sat_o   = sat_r;

  // Floor shift, optional translation, clip to the coordinate range
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      quot[i] = QW'(sum_i[i] >>> FRAC_BITS);
      res[i]  = RW'(quot[i]) + (flags_i.add_t ? RW'(trans_i[i]) : RW'(0));
      top_bits[i] = res[i][RW-1:CW-1];
      fits[i] = (top_bits[i] == '0) || (top_bits[i] == '1);
      if (fits[i]) begin
        vout_nxt[i] = res[i][CW-1:0];
      end else begin
        vout_nxt[i] = res[i][RW-1] ? VMIN : VMAX;
        sat_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      vout_r <= vout_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

// ===== src/affine_point_transform.sv =====
// Top level of the affine point transform: configuration registers and
// the four pipeline stages apt_prep, apt_mul, apt_sum, apt_sat (apt_pkg).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | slave     | tvalid / tready    | tdata: vin_x, vin_y, vin_z; tuser: cmd
//  out_    | master    | tvalid / tready    | tdata: vout_x, vout_y, vout_z;
//          |           |                    | tuser: saturated
//  cfg_    | write     | wr_en              | addr: register index, wdata
//
// One request per cycle sustained while the output is not stalled. The
// accepting edge loads the prepare stage; the multiply, sum and saturate
// registers follow in that order, and out_tvalid rises once saturate is loaded.
// Each stage holds its contents while the stage after it is full and
// stalled; empty stages fill even under a stall, so no bubble is kept.
// Synchronous reset empties the pipeline and loads the identity rotation
// with zero translation.
module affine_point_transform #(
  parameter int unsigned COORD_WIDTH = apt_pkg::COORD_W_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input requests
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,   // vin_x, vin_y, vin_z
  input  logic [1:0]                             in_tuser,   // cmd
  // Results
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,  // vout_x, vout_y, vout_z
  output logic                                   out_tuser,  // saturated
  // Configuration writes
  input  logic                                   cfg_wr_en,
  input  logic [apt_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [apt_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import apt_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned DATA_W = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned TW     = (CW < TRANS_W) ? CW : TRANS_W;

  // Configuration registers
  logic [ROW_W-1:0]     rot_row_r [DIM];
  logic [TW-1:0]        trans_r   [DIM];
  coef_t                rot       [DIM][DIM];
  logic signed [CW-1:0] trans     [DIM];

  // Pipeline links
  logic                  p1_valid, p1_ready;
  op_flags_t             p1_flags;
  logic signed [CW:0]    p1_opnd [DIM];
  logic                  p2_valid, p2_ready;
  op_flags_t             p2_flags;
  logic signed [CW+16:0] p2_prod [DIM][DIM];
  logic                  p3_valid, p3_ready;
  op_flags_t             p3_flags;
  logic signed [CW+18:0] p3_sum  [DIM];
  logic signed [CW-1:0]  vin     [DIM];
  logic signed [CW-1:0]  vout    [DIM];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        rot_row_r[r] <= ROW_W'(COEF_ONE) << (r * COEF_W);
        trans_r[r]   <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_ROT_ROW0: rot_row_r[0] <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW1: rot_row_r[1] <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW2: rot_row_r[2] <= cfg_wdata[ROW_W-1:0];
        REG_TRANS_X:  trans_r[0]   <= cfg_wdata[TW-1:0];
        REG_TRANS_Y:  trans_r[1]   <= cfg_wdata[TW-1:0];
        REG_TRANS_Z:  trans_r[2]   <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients; widen translation (zero fill past 32 bits)
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        rot[r][c] = rot_row_r[r][c*COEF_W +: COEF_W];
      end
      trans[r] = CW'(trans_r[r]);
      vin[r]   = in_tdata[r*CW +: CW];
    end
  end

  apt_prep #(.CW(CW)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .cmd_i   (cmd_t'(in_tuser)),
    .vin_i   (vin),
    .trans_i (trans),
    .valid_o (p1_valid),
    .ready_i (p1_ready),
    .flags_o (p1_flags),
    .opnd_o  (p1_opnd)
  );

  apt_mul #(.CW(CW)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p1_valid),
    .ready_o (p1_ready),
    .flags_i (p1_flags),
    .opnd_i  (p1_opnd),
    .rot_i   (rot),
    .valid_o (p2_valid),
    .ready_i (p2_ready),
    .flags_o (p2_flags),
    .prod_o  (p2_prod)
  );

  apt_sum #(.CW(CW)) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p2_valid),
    .ready_o (p2_ready),
    .flags_i (p2_flags),
    .prod_i  (p2_prod),
    .valid_o (p3_valid),
    .ready_i (p3_ready),
    .flags_o (p3_flags),
    .sum_o   (p3_sum)
  );

  apt_sat #(.CW(CW)) u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p3_valid),
    .ready_o (p3_ready),
    .flags_i (p3_flags),
    .sum_i   (p3_sum),
    .trans_i (trans),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .vout_o  (vout),
    .sat_o   (out_tuser)
  );

  // Pack result components, x lowest, zero padded to whole bytes
  assign out_tdata = DATA_W'({vout[2], vout[1], vout[0]});

endmodule
